// ===== rtl/core/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime test core.
`timescale 1ns / 1ps

package tdpt_pkg;

   // Smallest prime, and the first odd trial divisor.
   localparam int SMALLEST_PRIME = 2;
   localparam int FIRST_DIVISOR  = 3;

   // Status from the serial remainder unit back to the sequencer.
   typedef struct packed {
      logic done;      // one-cycle pulse: remainder is final
      logic rem_zero;  // remainder is zero, valid with done
   } rem_status_type;

endpackage

// ===== rtl/core/tdpt_rem_unit.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module tdpt_rem_unit #(
   parameter int NUM_WIDTH = 32,
   parameter int DIV_WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [NUM_WIDTH-1:0]     dividend,
   input  logic [DIV_WIDTH-1:0]     divisor,
   output tdpt_pkg::rem_status_type status
);

   localparam int CNT_WIDTH = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

   logic [NUM_WIDTH-1:0] dvd_ff;
   logic [DIV_WIDTH-1:0] dsr_ff;
   logic [DIV_WIDTH-1:0] rem_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic                 run_ff;
   logic                 done_ff;

   logic [DIV_WIDTH:0]   trial;
   logic                 fits;

   // Shift the next dividend bit into the partial remainder and test it.
   assign trial = {rem_ff, dvd_ff[NUM_WIDTH-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff <= dividend;
            dsr_ff <= divisor;
            rem_ff <= '0;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            // Subtract when the divisor fits, otherwise keep the partial remainder.
            if (fits) begin
               rem_ff <= DIV_WIDTH'(trial - {1'b0, dsr_ff});
            end else begin
               rem_ff <= DIV_WIDTH'(trial);
            end
            dvd_ff <= {dvd_ff[NUM_WIDTH-2:0], 1'b0};
            cnt_ff <= cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == CNT_WIDTH'(NUM_WIDTH - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status = '{done: done_ff, rem_zero: (rem_ff == '0)};

endmodule

// ===== rtl/core/trial_division_prime_test_core.sv =====
// Top level of the trial-division prime test core: sequencer and result register.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid, req_stall, req_value): one signed number per
//   transaction. req_stall is high while a test is in progress; the core takes
//   a new transaction only from its idle state.
//   Response channel (rsp_valid, rsp_stall, rsp_prime_flag): one transaction per
//   request, in order. The result sits in an output register, so the core goes
//   back to idle and takes the next request while an earlier result waits.
//   Negatives, 0, 1, 2 and even numbers go straight from idle to the finish
//   state. Odd numbers run odd divisors d = 3, 5, ... while d*d <= value; each
//   divisor costs one bound check plus a full pass of the bit-serial remainder
//   unit, which takes one dividend bit per cycle.
//   The bound d*d is kept as a running square (add 4d + 4 per step), so no
//   multiplier is needed.
//   When the receiver stalls, a finished result holds in the finish state
//   until the output register frees up; the request side stays stalled.
//   Reset (synchronous, active high) returns to idle and drops any pending
//   result.

module trial_division_prime_test_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_prime_flag
);

   // Divisor width covers sqrt of the largest positive value plus one step;
   // the running square is twice that wide and never overflows.
   localparam int DW = VALUE_WIDTH / 2 + 1;
   localparam int SW = 2 * DW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type                state_ff;
   logic [VALUE_WIDTH-1:0]   value_ff;
   logic [DW-1:0]            div_ff;
   logic [SW-1:0]            sq_ff;
   logic                     prime_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_prime_flag_ff;

   logic                     req_take;
   logic                     out_free;
   logic                     bound_hit;
   logic                     rem_start;
   logic                     below_two;
   logic                     is_two;
   tdpt_pkg::rem_status_type rem_status;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Negatives, zero and one are never prime.
   assign below_two = req_value[VALUE_WIDTH-1] || (req_value[VALUE_WIDTH-1:1] == '0);
   assign is_two    = (req_value == VALUE_WIDTH'(tdpt_pkg::SMALLEST_PRIME));

   // Stop when the divisor squared passes the number: no factor found.
   assign bound_hit = (sq_ff > SW'(value_ff));
   assign rem_start = (state_ff == ST_CHECK) && !bound_hit;

   tdpt_rem_unit #(
      .NUM_WIDTH (VALUE_WIDTH),
      .DIV_WIDTH (DW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (value_ff),
      .divisor  (div_ff),
      .status   (rem_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once the receiver takes it, unless a new one loads.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  value_ff <= req_value;
                  div_ff   <= DW'(tdpt_pkg::FIRST_DIVISOR);
                  sq_ff    <= SW'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
                  priority if (is_two) begin
                     prime_ff <= 1'b1;
                     state_ff <= ST_FINISH;
                  end else if (below_two || !req_value[0]) begin
                     prime_ff <= 1'b0;
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               if (bound_hit) begin
                  prime_ff <= 1'b1;
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (rem_status.done) begin
                  if (rem_status.rem_zero) begin
                     prime_ff <= 1'b0;
                     state_ff <= ST_FINISH;
                  end else begin
                     // Advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4.
                     div_ff   <= div_ff + DW'(2);
                     sq_ff    <= sq_ff + SW'({div_ff, 2'b00}) + SW'(4);
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_FINISH: begin
               // Hold until the output register is free.
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_prime_flag_ff <= prime_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prime_flag = rsp_prime_flag_ff;

   // Trial divisors are always odd while the bound is checked.
   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> div_ff[0])
      else $error("even trial divisor in bound check");

   // The remainder unit reports only while the sequencer waits for it.
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      rem_status.done |-> (state_ff == ST_DIVIDE))
      else $error("remainder done outside divide state");

   // An accepted transaction always leaves the idle state.
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start a test");

   // A result is loaded only when the output register could take it.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && state_ff == ST_FINISH) |=>
         (state_ff == ST_FINISH))
      else $error("result overwrote a pending response");

endmodule

// ===== tb/trial_division_prime_checker.sv =====
// Checker for the trial-division prime test core: predicts each verdict and compares.
`timescale 1ns / 1ps

module trial_division_prime_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_prime_flag,
   output int                            error_count,
   output int                            pending_count,
   output int                            primes_seen
);

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] number;
      logic                          prime;
   } verdict_type;

   verdict_type              expected_verdicts[$];

   // Trial division with an exact d*d <= n bound in 64 bits.
   function automatic logic predict_prime(input logic signed [VALUE_WIDTH-1:0] number);
      longint unsigned n;
      longint unsigned d;
      if (number < 0) return 1'b0;
      n = number;
      if (n == tdpt_pkg::SMALLEST_PRIME) return 1'b1;
      if (n < tdpt_pkg::SMALLEST_PRIME || n[0] == 1'b0) return 1'b0;
      for (d = tdpt_pkg::FIRST_DIVISOR; d * d <= n; d += 2) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      verdict_type oldest;
      verdict_type fresh;
      if (reset) begin
         expected_verdicts.delete();
         error_count   = 0;
         primes_seen   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected result prime_flag %0b with nothing pending",
                        $time, rsp_prime_flag);
               error_count = error_count + 1;
            end else begin
               oldest = expected_verdicts.pop_front();
               if (rsp_prime_flag !== oldest.prime) begin
                  $display("%0t: value %0d expected prime_flag %0b, got %0b",
                           $time, oldest.number, oldest.prime, rsp_prime_flag);
                  error_count = error_count + 1;
               end
               if (rsp_prime_flag === 1'b1) primes_seen = primes_seen + 1;
            end
         end
         if (req_valid && !req_stall) begin
            fresh.number = req_value;
            fresh.prime  = predict_prime(req_value);
            expected_verdicts.push_back(fresh);
         end
      end
      pending_count = expected_verdicts.size();
   end

endmodule

// ===== tb/tb_trial_division_prime_test_core.sv =====
// Testbench top for the trial-division prime test core: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_trial_division_prime_test_core;

   localparam int VALUE_WIDTH     = 32;
   // Receiver hold-off long enough to fill the result register and stall input.
   localparam int HOLD_OFF_CYCLES = 300;
   // A 31-bit prime runs its whole test with no transaction moving; the limit
   // must cover the longest such test before declaring a hang.
   localparam int IDLE_LIMIT      = 3_000_000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_prime_flag;

   int   error_count;
   int   pending_count;
   int   primes_seen;
   int   numbers_sent = 0;
   int   idle_cycles = 0;
   // steady: neither side idles. hold_off_request: ask the receiver for one long stall.
   logic steady = 1'b0;
   logic hold_off_request = 1'b0;

   trial_division_prime_test_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_prime_flag(rsp_prime_flag)
   );

   trial_division_prime_checker #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) verdict_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_prime_flag(rsp_prime_flag),
      .error_count(error_count),
      .pending_count(pending_count),
      .primes_seen(primes_seen)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Offer one number: idle for a random gap, then hold it until the core takes it.
   // Return at the falling edge after the transaction.
   task automatic send_number(input logic signed [VALUE_WIDTH-1:0] number);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= number;
      do @(posedge clock); while (req_stall);
      numbers_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected verdict has come back.
   task automatic drain;
      req_valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   // Draw a number. Most are small or resolve after a few divisors, since a test
   // runs one remainder pass per odd divisor up to sqrt(n).
   function automatic logic signed [VALUE_WIDTH-1:0] pick_number();
      int unsigned roll;
      int unsigned a;
      int unsigned b;
      int unsigned t;
      roll = $urandom_range(0, 99);
      a    = 2 * $urandom_range(1, 127) + 1;
      b    = 2 * $urandom_range(1, 127) + 1;
      if (roll < 40) return $urandom_range(0, 4095);
      if (roll < 55) begin
         // negative: random low bits, sign bit forced
         t     = $urandom;
         t[31] = 1'b1;
         return t;
      end
      if (roll < 75) begin
         // large multiple of three: even ones finish at once, odd ones exit at the first divisor
         t = $urandom_range(32'h7FFF_FFFF, 32'h0001_0000);
         return t - t % 3;
      end
      if (roll < 85) return a * b;
      if (roll < 95) return $urandom_range(4096, 262143);
      // odd square: when a is prime, the loop bound lands exactly on d*d == n
      return a * a;
   endfunction

   // Receiver: for each result draw a stall length, or take the long hold-off
   // when asked, then accept the next result.
   initial begin : receiver
      int wait_cycles;
      @(negedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            wait_cycles      = HOLD_OFF_CYCLES;
         end else begin
            wait_cycles = steady ? 0 : $urandom_range(0, 6);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("** trial_division_prime_test_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int n;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: sign extremes, 0 to 5, small squares, primes around 2^16,
      // alternating bit patterns and the top of the positive range.
      send_number(32'sh8000_0000);
      send_number(-32'sd1);
      send_number(32'sd0);
      send_number(32'sd1);
      send_number(tdpt_pkg::SMALLEST_PRIME);
      send_number(tdpt_pkg::FIRST_DIVISOR);
      send_number(32'sd4);
      send_number(32'sd5);
      send_number(32'sd9);
      send_number(32'sd15);
      send_number(32'sd25);
      send_number(32'sd49);
      send_number(32'sd63001);
      send_number(32'sd65521);
      send_number(32'sd65537);
      send_number(32'sh5555_5555);
      send_number(32'sh2AAA_AAAA);
      send_number(32'sd2147483646);
      send_number(32'sd2147483645);
      // largest positive value is prime: the longest test the core can run
      send_number(32'sd2147483647);

      for (n = 0; n < 20; n++) send_number(pick_number());

      // Hold off the receiver while quick numbers keep coming, so the result
      // register fills and the core stalls its input.
      hold_off_request = 1'b1;
      for (n = 0; n < 10; n++) send_number($urandom_range(0, 64));

      // Pause the sender until the core is empty.
      drain();

      // Back-to-back stretch with no idling on either side.
      steady = 1'b1;
      for (n = 0; n < 20; n++) send_number(pick_number());
      steady = 1'b0;

      for (n = 0; n < 25; n++) send_number(pick_number());

      drain();
      repeat (50) @(posedge clock);

      $display("Tested %0d numbers (%0d reported prime): negatives, 0 to 5, odd squares,",
               numbers_sent, primes_seen);
      $display("31-bit extremes, random gaps, a %0d-cycle hold-off and back-to-back traffic.",
               HOLD_OFF_CYCLES);
      if (error_count == 0) begin
         $display("** trial_division_prime_test_core: PASSED **");
      end else begin
         $display("** trial_division_prime_test_core: FAILED **");
      end
      $finish;
   end

endmodule
